// ===== rtl/hsvled_pkg.sv =====
// ----------------------------------------------------------------------------
// hsvled_pkg
// Shared types and constants of the HSV LED pulse encoder.
// ----------------------------------------------------------------------------
package hsvled_pkg;

    localparam int unsigned PULSES_PER_LED = 24;
    localparam int unsigned SEXTANT_DEG    = 60;
    localparam int unsigned FULL_CIRCLE    = 360;
    localparam int unsigned GREY_LEVEL     = 255;

    // x / 60 == (x * 17477) >> 20 for every x below 2^14
    localparam int unsigned RECIP_60    = 17477;
    localparam int unsigned RECIP_SHIFT = 20;

    localparam logic [7:0] ONE_COMPARE_RST  = 8'd20;
    localparam logic [7:0] ZERO_COMPARE_RST = 8'd7;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_ONE_IDX  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ZERO_IDX = 8'd1;

    localparam int unsigned CNT_W = $clog2(PULSES_PER_LED);

    typedef enum logic [2:0] {
        SEXT_0 = 3'd0,
        SEXT_1 = 3'd1,
        SEXT_2 = 3'd2,
        SEXT_3 = 3'd3,
        SEXT_4 = 3'd4,
        SEXT_5 = 3'd5
    } sextant_t;

    // one converted LED word, green/red/blue from high to low byte
    typedef struct packed {
        logic        valid;
        logic [23:0] grb;
    } grb_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== rtl/hsv_led_pulse_encoder_top.sv =====
// ----------------------------------------------------------------------------
// hsv_led_pulse_encoder_top
// HSV colour to LED bit-pulse encoder.
// ----------------------------------------------------------------------------
// Each request on the slave stream is one LED colour (hue 0..359, whiteness,
// brightness). A three-stage pipeline converts it to 8-bit red, green and
// blue with the integer sextant formula (whiteness 255 gives grey; a hue of
// 360 or more wraps by 360) and drops the 24-bit GRB word into a two-entry
// queue. The back end pops words and sends 24 requests per LED on the master
// stream, MSB of green first, one per cycle while m_tready is high, the 24th
// with tlast high. Each carries one_compare or zero_compare in tdata and the
// encoded bit in tuser. The serializer pops the next word straight after the
// last pulse of the one before, so LEDs follow back to back.
// The slave side keeps accepting while the pipeline and queue have room, so
// up to six colours may be in flight. Configuration registers (index 0:
// one_compare, reset 20; index 1: zero_compare, reset 7) are written through
// the cfg channel, which is always ready; other indexes are ignored. Write
// them only while the block is idle.
// ----------------------------------------------------------------------------
module hsv_led_pulse_encoder_top
    import hsvled_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // [8:0] hue, [16:9] whiteness,
                                              // [24:17] brightness, rest zero
    // master stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [7:0]             m_tdata,   // [7:0] pulse_compare
    output logic                   m_tuser,   // [0] data_bit
    output logic                   m_tlast,   // last_of_led
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    logic [7:0]  one_compare_reg;
    logic [7:0]  zero_compare_reg;

    grb_req_t    push;
    q_status_t   q_status;
    logic [23:0] q_data;
    logic        pop;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            one_compare_reg  <= ONE_COMPARE_RST;
            zero_compare_reg <= ZERO_COMPARE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ONE_IDX:  one_compare_reg  <= cfg_data;
                CFG_ZERO_IDX: zero_compare_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // front: colour conversion
    hsvled_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (s_tdata[8:0]),
        .whiteness  (s_tdata[16:9]),
        .brightness (s_tdata[24:17]),
        .q_full     (q_status.full),
        .push       (push)
    );

    // decoupling queue
    hsvled_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .rd_data (q_data),
        .status  (q_status)
    );

    // back: bit serializer with output register
    hsvled_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .q_data       (q_data),
        .pop          (pop),
        .one_compare  (one_compare_reg),
        .zero_compare (zero_compare_reg),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_compare  (m_tdata),
        .out_bit      (m_tuser),
        .out_last     (m_tlast)
    );

    // the queue never pushes while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !q_status.full)
        else $error("push into full queue");

    // the queue never pops while empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // the front stalls only on back-pressure from a full queue
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> q_status.full)
        else $error("front stalled without a full queue");

    // a word is popped only when the output register is free to load
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!m_tvalid || m_tready))
        else $error("pop while output stalled");

endmodule

// ===== rtl/hsvled_front.sv =====
// ----------------------------------------------------------------------------
// hsvled_front
// Three-stage HSV to GRB conversion pipeline; stalls only when the queue is full.
// ----------------------------------------------------------------------------
module hsvled_front
    import hsvled_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [8:0] hue,
    input  logic [7:0] whiteness,
    input  logic [7:0] brightness,
    input  logic       q_full,
    output grb_req_t   push
);

    // stage 1
    logic        s1_valid_reg;
    logic [15:0] s1_prod_reg;
    logic [7:0]  s1_v_reg;
    logic        s1_grey_reg;
    sextant_t    s1_sext_reg;
    logic [5:0]  s1_frac_reg;
    // stage 2
    logic        s2_valid_reg;
    logic [13:0] s2_num_reg;
    logic [7:0]  s2_base_reg;
    logic [7:0]  s2_v_reg;
    logic        s2_grey_reg;
    sextant_t    s2_sext_reg;
    // stage 3
    logic        s3_valid_reg;
    logic [7:0]  s3_quo_reg;
    logic [7:0]  s3_base_reg;
    logic [7:0]  s3_v_reg;
    logic        s3_grey_reg;
    sextant_t    s3_sext_reg;

    logic        adv;
    logic [8:0]  hue_w;
    sextant_t    sext_next;
    logic [8:0]  sext_start;
    logic [5:0]  f_w;
    logic [5:0]  frac_next;
    logic [7:0]  base_w;
    logic [7:0]  diff_w;
    logic [28:0] recip_prod;
    logic [7:0]  ramp_w;
    logic [7:0]  r_w;
    logic [7:0]  g_w;
    logic [7:0]  b_w;

    assign adv      = !(s3_valid_reg && q_full);
    assign in_ready = adv;

    // stage 1 logic: wrap, sextant, fraction
    always_comb
    begin
        hue_w = (hue >= 9'(FULL_CIRCLE)) ? hue - 9'(FULL_CIRCLE) : hue;
        priority if (hue_w >= 9'd300)
        begin
            sext_next  = SEXT_5;
            sext_start = 9'd300;
        end
        else if (hue_w >= 9'd240)
        begin
            sext_next  = SEXT_4;
            sext_start = 9'd240;
        end
        else if (hue_w >= 9'd180)
        begin
            sext_next  = SEXT_3;
            sext_start = 9'd180;
        end
        else if (hue_w >= 9'd120)
        begin
            sext_next  = SEXT_2;
            sext_start = 9'd120;
        end
        else if (hue_w >= 9'(SEXTANT_DEG))
        begin
            sext_next  = SEXT_1;
            sext_start = 9'(SEXTANT_DEG);
        end
        else
        begin
            sext_next  = SEXT_0;
            sext_start = 9'd0;
        end
        f_w = 6'(hue_w - sext_start);
        // odd sextants ramp down
        frac_next = sext_next[0] ? 6'(SEXTANT_DEG) - f_w : f_w;
    end

    // stage 2 logic
    assign base_w = s1_prod_reg[15:8];
    assign diff_w = s1_v_reg - base_w;

    // stage 3 logic: divide by 60 through reciprocal
    assign recip_prod = 29'(s2_num_reg) * 29'(RECIP_60);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_prod_reg <= 16'(whiteness) * 16'(brightness);
            s1_v_reg    <= brightness;
            s1_grey_reg <= (whiteness == 8'(GREY_LEVEL));
            s1_sext_reg <= sext_next;
            s1_frac_reg <= frac_next;

            // 8x6 product, at most 255 * 60
            s2_num_reg  <= 14'(diff_w) * 14'(s1_frac_reg);
            s2_base_reg <= base_w;
            s2_v_reg    <= s1_v_reg;
            s2_grey_reg <= s1_grey_reg;
            s2_sext_reg <= s1_sext_reg;

            s3_quo_reg  <= recip_prod[RECIP_SHIFT+7:RECIP_SHIFT];
            s3_base_reg <= s2_base_reg;
            s3_v_reg    <= s2_v_reg;
            s3_grey_reg <= s2_grey_reg;
            s3_sext_reg <= s2_sext_reg;
        end
    end

    // component selection
    always_comb
    begin
        ramp_w = s3_quo_reg + s3_base_reg;
        unique case (s3_sext_reg)
            SEXT_0:
            begin
                r_w = s3_v_reg;    g_w = ramp_w;      b_w = s3_base_reg;
            end
            SEXT_1:
            begin
                r_w = ramp_w;      g_w = s3_v_reg;    b_w = s3_base_reg;
            end
            SEXT_2:
            begin
                r_w = s3_base_reg; g_w = s3_v_reg;    b_w = ramp_w;
            end
            SEXT_3:
            begin
                r_w = s3_base_reg; g_w = ramp_w;      b_w = s3_v_reg;
            end
            SEXT_4:
            begin
                r_w = ramp_w;      g_w = s3_base_reg; b_w = s3_v_reg;
            end
            default:
            begin
                r_w = s3_v_reg;    g_w = s3_base_reg; b_w = ramp_w;
            end
        endcase
        if (s3_grey_reg)
        begin
            r_w = s3_v_reg;
            g_w = s3_v_reg;
            b_w = s3_v_reg;
        end
    end

    assign push.valid = s3_valid_reg && !q_full;
    assign push.grb   = {g_w, r_w, b_w};

endmodule

// ===== rtl/hsvled_queue.sv =====
// ----------------------------------------------------------------------------
// hsvled_queue
// Two-entry FIFO of converted GRB words between front and back.
// ----------------------------------------------------------------------------
module hsvled_queue
    import hsvled_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  grb_req_t    push,
    input  logic        pop,
    output logic [23:0] rd_data,
    output q_status_t   status
);

    logic [23:0] mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push.valid)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem_reg[wr_ptr_reg] <= push.grb;
    end

endmodule

// ===== rtl/hsvled_back.sv =====
// ----------------------------------------------------------------------------
// hsvled_back
// Serializes each GRB word MSB first into 24 registered pulse requests.
// ----------------------------------------------------------------------------
module hsvled_back
    import hsvled_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_status_t   q_status,
    input  logic [23:0] q_data,
    output logic        pop,
    input  logic [7:0]  one_compare,
    input  logic [7:0]  zero_compare,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_compare,
    output logic        out_bit,
    output logic        out_last
);

    logic             valid_reg;
    logic [7:0]       compare_reg;
    logic             bit_reg;
    logic             last_reg;
    logic [22:0]      word_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             load;
    logic             from_word;
    logic             next_bit;

    assign load      = !valid_reg || out_ready;
    assign from_word = (cnt_reg != '0);
    assign pop       = load && !from_word && !q_status.empty;
    assign next_bit  = from_word ? word_reg[22] : q_data[23];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else if (load)
        begin
            if (from_word)
            begin
                valid_reg <= 1'b1;
                cnt_reg   <= cnt_reg - CNT_W'(1);
            end
            else if (!q_status.empty)
            begin
                valid_reg <= 1'b1;
                cnt_reg   <= CNT_W'(PULSES_PER_LED - 1);
            end
            else
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            compare_reg <= next_bit ? one_compare : zero_compare;
            bit_reg     <= next_bit;
            last_reg    <= from_word && (cnt_reg == CNT_W'(1));
            word_reg    <= from_word ? {word_reg[21:0], 1'b0} : q_data[22:0];
        end
    end

    assign out_valid   = valid_reg;
    assign out_compare = compare_reg;
    assign out_bit     = bit_reg;
    assign out_last    = last_reg;

endmodule
